// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MTSS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtss assertion failed");

// next-cycle implication
`define MTSS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtss assertion failed");

`endif

// ----- hdl/mtss_pkg.sv -----
// ---------------------------------------------------------------------------
// mtss_pkg
// Types and constants for the motor tension stop sequencer.
// ---------------------------------------------------------------------------
package mtss_pkg;

   // command codes on the request side
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;

   // bridge drive codes
   localparam logic [1:0] DRV_FWD     = 2'd0;
   localparam logic [1:0] DRV_REV     = 2'd1;
   localparam logic [1:0] DRV_STANDBY = 2'd2;
   localparam logic [1:0] DRV_BRAKE   = 2'd3;

   // stop causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_RISING  = 2'd1;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

   // configuration register indexes
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd20000;
   localparam int unsigned SCALE_DIV     = 500;
   localparam int unsigned QUEUE_DEPTH   = 4;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_SAMPLE,
      KIND_START,
      KIND_NOP
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BASE,
      PH_RUN,
      PH_HOLD,
      PH_SETTLE
   } phase_type;

   // one classified word between front and back
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         dir;
      logic signed [15:0] tension;
   } entry_type;

   // one result word
   typedef struct packed {
      logic               pin_a;
      logic               pin_b;
      logic signed [15:0] tension;
      logic               busy;
      logic [1:0]         cause;
      logic               fin;
      logic               last;
   } result_type;

endpackage

// ----- hdl/mtss_queue.sv -----
// ---------------------------------------------------------------------------
// mtss_queue
// Small register queue that decouples the classifier from the sequencer.
// ---------------------------------------------------------------------------
module mtss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mtss_pkg::entry_type push_word,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mtss_pkg::entry_type pop_word
);
   import mtss_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/mtss_front.sv -----
// ---------------------------------------------------------------------------
// mtss_front
// Accepts request words, decodes the command and scales the load sample
// by 1/500 (truncating, clamped to 16 bits) in a two-stage pipeline.
// ---------------------------------------------------------------------------
module mtss_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [1:0]             in_cmd,
   input  logic [1:0]             in_dir,
   input  logic [SAMPLE_BITS-1:0] in_raw,
   output logic                   push_valid,
   input  logic                   push_ready,
   output mtss_pkg::entry_type    push_word
);
   import mtss_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int QW = SB - 8;
   // reciprocal with SB fraction bits; quotient estimate is exact or one low
   localparam logic [QW-1:0] RECIP = QW'((64'd1 << SB) / 64'(SCALE_DIV));

   // stage A: classify, split sign and magnitude
   logic              a_v_ff;
   kind_type          a_kind_ff, a_kind_in;
   logic [1:0]        a_dir_ff;
   logic              a_neg_ff;
   logic [SB-1:0]     a_mag_ff, a_mag_in;

   // stage B: quotient estimate
   logic              b_v_ff;
   kind_type          b_kind_ff;
   logic [1:0]        b_dir_ff;
   logic              b_neg_ff;
   logic [SB-1:0]     b_mag_ff;
   logic [QW-1:0]     b_q0_ff, b_q0_in;
   logic [2*SB-9:0]   product;

   logic              b_ready, a_ready;
   logic [SB-1:0]     rem;
   logic [QW-1:0]     quo;
   logic [32:0]       quo_ext;
   logic signed [15:0] tension;

   assign b_ready  = !b_v_ff || push_ready;
   assign a_ready  = !a_v_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      case (in_cmd)
         CMD_TICK:   a_kind_in = KIND_TICK;
         CMD_SAMPLE: a_kind_in = KIND_SAMPLE;
         CMD_START:  a_kind_in = KIND_START;
         default:    a_kind_in = KIND_NOP;
      endcase
      a_mag_in = in_raw[SB-1] ? (~in_raw + 1'b1) : in_raw;
   end

   assign product = (2*SB-8)'(a_mag_ff) * (2*SB-8)'(RECIP);
   assign b_q0_in = product[2*SB-9:SB];

   // one correction step, then sign and clamp
   always_comb begin
      rem     = b_mag_ff - SB'(b_q0_ff) * SB'(SCALE_DIV);
      quo     = (rem >= SB'(SCALE_DIV)) ? b_q0_ff + 1'b1 : b_q0_ff;
      quo_ext = 33'(quo);
      if (!b_neg_ff) begin
         tension = (quo_ext > 33'd32767) ? 16'sd32767 : 16'(quo);
      end else begin
         tension = (quo_ext > 33'd32768) ? -16'sd32768 : -16'(quo);
      end
   end

   assign push_valid        = b_v_ff;
   assign push_word.kind    = b_kind_ff;
   assign push_word.dir     = b_dir_ff;
   assign push_word.tension = tension;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_v_ff <= in_valid;
         end
         if (b_ready) begin
            b_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_kind_ff <= a_kind_in;
         a_dir_ff  <= in_dir;
         a_neg_ff  <= in_raw[SB-1];
         a_mag_ff  <= a_mag_in;
      end
      if (b_ready && a_v_ff) begin
         b_kind_ff <= a_kind_ff;
         b_dir_ff  <= a_dir_ff;
         b_neg_ff  <= a_neg_ff;
         b_mag_ff  <= a_mag_ff;
         b_q0_ff   <= b_q0_in;
      end
   end

endmodule

// ----- hdl/mtss_back.sv -----
// ---------------------------------------------------------------------------
// mtss_back
// Run sequencer: takes classified words from the queue, steps the run,
// stop, hold and settle phases, and drives the result register.
// ---------------------------------------------------------------------------
module mtss_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [15:0]         csr_wdata,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  mtss_pkg::entry_type pop_word,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output mtss_pkg::result_type rsp_word
);
   import mtss_pkg::*;

   logic signed [15:0] thresh_ff;
   logic [15:0]        timeout_ff;

   phase_type          phase_ff, phase_in;
   logic [1:0]         run_dir_ff, run_dir_in;
   logic [1:0]         drive_ff, drive_in;
   logic signed [15:0] tens_ff, tens_in;
   logic [15:0]        elapsed_ff, elapsed_in;
   logic [1:0]         left_ff, left_in;
   logic [1:0]         cause_ff, cause_in;
   logic               two, fin;

   logic               out_v_ff;
   result_type         out_ff;
   logic               pend_v_ff;
   result_type         pend_ff;
   result_type         res_first, res_second;

   logic               take;
   logic               rising_over, timed_out;
   logic [1:0]         left_dec;

   assign pop_ready = !pend_v_ff && (!out_v_ff || rsp_tready);
   assign take      = pop_valid && pop_ready;

   assign rising_over = (pop_word.tension > thresh_ff) && (tens_ff < pop_word.tension);
   assign timed_out   = (elapsed_ff >= timeout_ff);
   assign left_dec    = left_ff - 1'b1;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      run_dir_in = run_dir_ff;
      drive_in   = drive_ff;
      tens_in    = tens_ff;
      elapsed_in = elapsed_ff;
      left_in    = left_ff;
      cause_in   = cause_ff;
      two        = 1'b0;
      fin        = 1'b0;
      if (take) begin
         case (pop_word.kind)
            KIND_TICK: begin
               if ((phase_ff == PH_BASE || phase_ff == PH_RUN) && elapsed_ff != 16'hFFFF) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            KIND_START: begin
               if (phase_ff == PH_IDLE) begin
                  run_dir_in = pop_word.dir;
                  elapsed_in = '0;
                  cause_in   = CAUSE_NONE;
                  left_in    = '0;
                  phase_in   = PH_BASE;
               end
            end
            KIND_SAMPLE: begin
               tens_in = pop_word.tension;
               case (phase_ff)
                  PH_BASE: begin
                     drive_in = run_dir_ff;
                     phase_in = PH_RUN;
                  end
                  PH_RUN: begin
                     if (rising_over || timed_out) begin
                        cause_in = rising_over ? CAUSE_RISING : CAUSE_TIMEOUT;
                        if (run_dir_ff == DRV_FWD) begin
                           drive_in = DRV_REV;
                        end else if (run_dir_ff == DRV_REV) begin
                           drive_in = DRV_FWD;
                        end
                        left_in  = 2'd2;
                        phase_in = PH_HOLD;
                     end
                  end
                  PH_HOLD: begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        // brake word, then standby word
                        two      = 1'b1;
                        drive_in = DRV_STANDBY;
                        left_in  = 2'd2;
                        phase_in = PH_SETTLE;
                     end
                  end
                  PH_SETTLE: begin
                     left_in = left_dec;
                     if (left_dec == '0) begin
                        fin      = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // result words
   always_comb begin
      res_first.pin_a   = two || drive_in == DRV_REV || drive_in == DRV_BRAKE;
      res_first.pin_b   = two || drive_in == DRV_FWD || drive_in == DRV_BRAKE;
      res_first.tension = tens_in;
      res_first.busy    = (phase_in != PH_IDLE);
      res_first.cause   = cause_in;
      res_first.fin     = fin;
      res_first.last    = !two;

      res_second.pin_a   = 1'b0;
      res_second.pin_b   = 1'b0;
      res_second.tension = tens_in;
      res_second.busy    = 1'b1;
      res_second.cause   = cause_in;
      res_second.fin     = 1'b0;
      res_second.last    = 1'b1;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_word   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff  <= '0;
         timeout_ff <= TIMEOUT_RESET;
         phase_ff   <= PH_IDLE;
         run_dir_ff <= DRV_FWD;
         drive_ff   <= DRV_STANDBY;
         tens_ff    <= '0;
         elapsed_ff <= '0;
         left_ff    <= '0;
         cause_ff   <= CAUSE_NONE;
         out_v_ff   <= 1'b0;
         pend_v_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_THRESHOLD: thresh_ff  <= csr_wdata;
               REG_TIMEOUT:   timeout_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         phase_ff   <= phase_in;
         run_dir_ff <= run_dir_in;
         drive_ff   <= drive_in;
         tens_ff    <= tens_in;
         elapsed_ff <= elapsed_in;
         left_ff    <= left_in;
         cause_ff   <= cause_in;
         if (take) begin
            out_v_ff  <= 1'b1;
            pend_v_ff <= two;
         end else if (out_v_ff && rsp_tready) begin
            if (pend_v_ff) begin
               pend_v_ff <= 1'b0;
            end else begin
               out_v_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff  <= res_first;
         pend_ff <= res_second;
      end else if (out_v_ff && rsp_tready && pend_v_ff) begin
         out_ff <= pend_ff;
      end
   end

endmodule

// ----- hdl/motor_tension_stop_sequencer.sv -----
// ---------------------------------------------------------------------------
// motor_tension_stop_sequencer
// H-bridge run sequencer that stops on rising load or on timeout.
// ---------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                       | tuser    | tlast
// req_    | in  | direction, raw_sample, zero pad          | command  | -
// rsp_    | out | pin_a, pin_b, scaled_tension, busy_res,  | finished | last_of_run
//         |     | stop_cause, zero pad                     |          |
// csr_    | in  | write enable, register index, 16-bit data| -        | -
//
// One request word per cycle is accepted while req_tready is high. A word
// passes the two scaling stages (A, B), then the four-entry queue, before it
// reaches the sequencer. Results leave one per cycle while rsp_tready is high.
// A word gives one result, the hold-to-settle sample gives two, set by the
// single result register and its second-word buffer. Reset is synchronous;
// a stalled rsp_ side fills the queue before req_tready drops.
module motor_tension_stop_sequencer #(
   parameter int SAMPLE_BITS = 24,
   localparam int REQ_W = ((SAMPLE_BITS + 2 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // direction[1:0], raw_sample, pad
   input  logic [1:0]       req_tuser,   // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,   // pin_a, pin_b, scaled_tension[15:0],
                                         // busy_res, stop_cause[1:0], pad
   output logic             rsp_tuser,   // finished
   output logic             rsp_tlast,   // last_of_run
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [15:0]      csr_wdata
);
   import mtss_pkg::*;

   logic       push_valid, push_ready;
   entry_type  push_word;
   logic       pop_valid, pop_ready;
   entry_type  pop_word;
   result_type rsp_word;

   mtss_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (req_tuser),
      .in_dir     (req_tdata[1:0]),
      .in_raw     (req_tdata[SAMPLE_BITS+1:2]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   mtss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   mtss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {3'b000, rsp_word.cause, rsp_word.busy, rsp_word.tension,
                       rsp_word.pin_b, rsp_word.pin_a};
   assign rsp_tuser = rsp_word.fin;
   assign rsp_tlast = rsp_word.last;

endmodule

// ----- hdl/mtss_checker.sv -----
// ---------------------------------------------------------------------------
// mtss_checker
// Port-level checks on the sequencer result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a finished word closes the sequence and reports idle
   `MTSS_ASSERT_NOW(a_fin_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `MTSS_ASSERT_NOW(a_fin_idle, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[18])
   // only the brake word is followed by a second word
   `MTSS_ASSERT_NOW(a_first_brake, clock, reset, rsp_tvalid && !rsp_tlast,
                    rsp_tdata[1:0] == 2'b11 && rsp_tdata[18])
   `MTSS_ASSERT_NOW(a_cause_code, clock, reset, rsp_tvalid, rsp_tdata[20:19] != 2'b11)
   `MTSS_ASSERT_NXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind motor_tension_stop_sequencer mtss_checker u_mtss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
